@@ src/crfs_pkg.sv @@
// Shared types, constants and helper functions for the Chladni ripple field sampler.
// Used by crfs_plate, crfs_radial and the core top level.
`timescale 1ns / 1ps

package crfs_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MODE_N  = 2'd0,
        REG_MODE_M  = 2'd1,
        REG_TENSION = 2'd2,
        REG_BEAT    = 2'd3
    } cfg_reg_t;

    // Published settings as seen by the datapath.
    typedef struct packed {
        logic [5:0]         mode_n;
        logic [5:0]         mode_m;
        logic signed [15:0] tension_level;
        logic [14:0]        beat_level;
    } crfs_cfg_t;

    // Half plate size and full plate size in world units.
    localparam int PLATE_HALF = 5000;
    localparam int PLATE_SPAN = 10000;

    // Falloff radius in world units.
    localparam int FALL_RADIUS = 5000;

    // Dividing by 10000 (coordinates) or 5000 (falloff) with rounding reduces to
    // floor((8192 * d + 312) / 625) style quotients; 1/625 is taken as a reciprocal.
    // The reciprocal error keeps the quotient exact for numerators below 2^26.
    localparam int          RECIP_SHIFT = 35;
    localparam logic [25:0] RECIP_625   = 26'd54975582;
    localparam logic [25:0] DIV_BIAS    = 26'd312;

    // Beat floor 0.15 in Q1.14 and blend weights in Q0.16.
    localparam logic [14:0]        BEAT_FLOOR = 15'd2458;
    localparam logic [15:0]        W_AMP      = 16'd45875;
    localparam logic signed [16:0] W_TEN      = 17'sd19661;

    // Register stages of the ripple path, counted from the input register.
    localparam int RIPPLE_LAT = 9;

    // Register stages of the radial path: two for the squares and their sum,
    // one per root bit, five for the falloff and tension scaling.
    function automatic int radial_lat(input int pos_bits);
        return pos_bits + 7;
    endfunction

    // cos(pi/2 * x) for x in Q0.15, result Q1.15 clamped to 0..32768.
    // Only evaluated at elaboration to build the cosine table.
    function automatic logic [15:0] quarter_cos(input int xq);
        longint z;
        longint t;
        longint r;
        z = longint'(xq) * longint'(xq);
        t = 30;
        t = 684 - ((t * z) >>> 30);
        t = 8312 - ((t * z) >>> 30);
        t = 40426 - ((t * z) >>> 30);
        r = 32768 - ((t * z) >>> 30);
        if (r < 0) begin
            r = 0;
        end
        if (r > 32768) begin
            r = 32768;
        end
        return 16'(r);
    endfunction

endpackage

@@ src/crfs_plate.sv @@
// Ripple amplitude pipeline: plate coordinates, cosine lookups, pattern and blend.
// Depends on crfs_pkg; all stages but tterm_reg advance together on the shared enable.
`timescale 1ns / 1ps

module crfs_plate #(
    parameter int COS_TABLE_BITS = 8,
    parameter int POS_BITS       = 24
) (
    input  logic                       aclk,
    input  logic                       en,
    input  crfs_pkg::crfs_cfg_t        cfg,
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    output logic [15:0]                ripple_amp
);

    localparam int QS     = 1 << COS_TABLE_BITS;
    localparam int PH_LSB = 15 - COS_TABLE_BITS;

    // Quarter-wave cosine table, built from constants at elaboration.
    logic [15:0] cos_lut [QS];

    for (genvar g = 0; g < QS; g++) begin : g_lut
        assign cos_lut[g] = crfs_pkg::quarter_cos(g << PH_LSB);
    end

    // Stage 1: offset onto the plate and multiply by the reciprocal of the span.
    logic signed [POS_BITS:0] tx, ty;
    logic [25:0]              mx, my;
    logic                     lox, hix, loy, hiy;

    always_comb begin
        tx  = (POS_BITS+1)'(pos_x) + (POS_BITS+1)'(crfs_pkg::PLATE_HALF);
        ty  = (POS_BITS+1)'(pos_y) + (POS_BITS+1)'(crfs_pkg::PLATE_HALF);
        lox = tx[POS_BITS] || (tx == '0);
        loy = ty[POS_BITS] || (ty == '0);
        hix = !tx[POS_BITS] && (tx >= (POS_BITS+1)'(crfs_pkg::PLATE_SPAN));
        hiy = !ty[POS_BITS] && (ty >= (POS_BITS+1)'(crfs_pkg::PLATE_SPAN));
        mx  = {tx[13:0], 12'd0} + crfs_pkg::DIV_BIAS;
        my  = {ty[13:0], 12'd0} + crfs_pkg::DIV_BIAS;
    end

    logic [51:0] prodx_reg, prody_reg;
    logic        lox_reg, hix_reg, loy_reg, hiy_reg;
    logic [16:0] u_reg, v_reg;

    // Stage 3: phases n*u, m*v, m*u, n*v, reduced to one turn.
    logic [22:0] ph_full [4];
    logic [16:0] phase_reg [4];

    always_comb begin
        ph_full[0] = 23'(cfg.mode_n) * 23'(u_reg);
        ph_full[1] = 23'(cfg.mode_m) * 23'(v_reg);
        ph_full[2] = 23'(cfg.mode_m) * 23'(u_reg);
        ph_full[3] = 23'(cfg.mode_n) * 23'(v_reg);
    end

    // Stage 4: quadrant fold and table lookup, one lane per cosine.
    logic signed [16:0] cos_next [4];
    logic signed [16:0] cos_reg [4];

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [1:0]                quad;
        logic [COS_TABLE_BITS-1:0] idx;
        logic [COS_TABLE_BITS-1:0] ridx;
        logic [15:0]               fwd;
        logic [15:0]               rev;

        always_comb begin
            quad = phase_reg[k][16:15];
            idx  = phase_reg[k][14 -: COS_TABLE_BITS];
            ridx = COS_TABLE_BITS'(0) - idx;
            fwd  = cos_lut[idx];
            // The mirrored index runs off the end of the table at zero, where cos is 0.
            rev  = (idx == '0) ? 16'd0 : cos_lut[ridx];
            case (quad)
                2'd0:    cos_next[k] = $signed({1'b0, fwd});
                2'd1:    cos_next[k] = -$signed({1'b0, rev});
                2'd2:    cos_next[k] = -$signed({1'b0, fwd});
                default: cos_next[k] = $signed({1'b0, rev});
            endcase
        end
    end

    // Stages 5 to 9: pattern products, magnitude, beat scale, weight, blend.
    logic signed [33:0] a_reg, b_reg;
    logic signed [34:0] diff;
    logic [34:0]        diff_mag;
    logic [31:0]        mag_reg;
    logic [14:0]        beat;
    logic [46:0]        beat_prod;
    logic [34:0]        amp_reg;
    logic [50:0]        wamp_reg;
    logic signed [31:0] tterm_reg;
    logic signed [52:0] sum;
    logic [52:0]        rsum;
    logic [15:0]        ripple_next;
    logic [15:0]        ripple_reg;

    always_comb begin
        diff      = 35'(a_reg) - 35'(b_reg);
        diff_mag  = diff[34] ? 35'(-diff) : 35'(diff);
        beat      = (cfg.beat_level < crfs_pkg::BEAT_FLOOR) ? crfs_pkg::BEAT_FLOOR
                                                            : cfg.beat_level;
        beat_prod = 47'(mag_reg) * 47'(beat);
        sum       = $signed({2'b00, wamp_reg}) + $signed({{3{tterm_reg[31]}}, tterm_reg, 18'd0});
        rsum      = 53'(sum) + 53'(64'h8000_0000);
        // Non-positive blends give zero; anything past one saturates.
        if (sum[52] || (sum == '0)) begin
            ripple_next = 16'd0;
        end else if (rsum[52:48] != '0) begin
            ripple_next = 16'hFFFF;
        end else begin
            ripple_next = rsum[47:32];
        end
    end

    // Pipeline registers; the payload carries no reset.
    always_ff @(posedge aclk) begin
        tterm_reg <= 32'(cfg.tension_level) * 32'(crfs_pkg::W_TEN);
        if (en) begin
            prodx_reg <= 52'(mx) * 52'(crfs_pkg::RECIP_625);
            prody_reg <= 52'(my) * 52'(crfs_pkg::RECIP_625);
            lox_reg   <= lox;
            hix_reg   <= hix;
            loy_reg   <= loy;
            hiy_reg   <= hiy;
            u_reg     <= hix_reg ? 17'h10000 : (lox_reg ? 17'd0 : prodx_reg[51:35]);
            v_reg     <= hiy_reg ? 17'h10000 : (loy_reg ? 17'd0 : prody_reg[51:35]);
            for (int k = 0; k < 4; k++) begin
                phase_reg[k] <= ph_full[k][16:0];
                cos_reg[k]   <= cos_next[k];
            end
            a_reg      <= 34'(cos_reg[0]) * 34'(cos_reg[1]);
            b_reg      <= 34'(cos_reg[2]) * 34'(cos_reg[3]);
            mag_reg    <= diff_mag[31:0];
            amp_reg    <= beat_prod[46:12];
            wamp_reg   <= 51'(amp_reg) * 51'(crfs_pkg::W_AMP);
            ripple_reg <= ripple_next;
        end
    end

    assign ripple_amp = ripple_reg;

endmodule

@@ src/crfs_radial.sv @@
// Radial falloff pipeline: squared radius, one root bit per stage, falloff and tension.
// Depends on crfs_pkg; carries the valid bits of the whole datapath.
`timescale 1ns / 1ps

module crfs_radial #(
    parameter int POS_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  crfs_pkg::crfs_cfg_t        cfg,
    input  logic                       in_valid,
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    output logic                       out_valid,
    output logic [15:0]                falloff_gain,
    output logic [15:0]                scaled_tension
);

    localparam int W = 2 * POS_BITS;
    localparam int K = POS_BITS;

    // Squares of the coordinates.
    logic [W-1:0] sqx_reg, sqy_reg;
    logic         sq_vld_reg;

    // Root extraction: remainder and partial root, one stage per root bit.
    logic [W-1:0] rem_reg  [K];
    logic [W-1:0] root_reg [K+1];
    logic         vld_reg  [K+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg <= in_valid;
            vld_reg[0] <= sq_vld_reg;
        end
        if (en) begin
            sqx_reg     <= W'(pos_x) * W'(pos_x);
            sqy_reg     <= W'(pos_y) * W'(pos_y);
            rem_reg[0]  <= sqx_reg + sqy_reg;
            root_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < K; s++) begin : g_root
        localparam logic [W-1:0] STEP_BIT = W'(1) << (2 * (K - 1 - s));
        logic [W-1:0] trial;
        logic         take;

        always_comb begin
            trial = root_reg[s] + STEP_BIT;
            take  = rem_reg[s] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
            if (en) begin
                root_reg[s+1] <= take ? ((root_reg[s] >> 1) + STEP_BIT) : (root_reg[s] >> 1);
            end
        end

        // The last stage only needs the root.
        if (s < K - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1] <= take ? (rem_reg[s] - trial) : rem_reg[s];
                end
            end
        end
    end

    // Falloff: round((5000 - r) * 65536 / 5000) inside the radius, zero outside.
    logic [POS_BITS-1:0] radius;
    logic [25:0]         div_num;
    logic                near_reg, near2_reg;
    logic [12:0]         dist_reg;
    logic [51:0]         fprod_reg;
    logic [16:0]         fall_reg;
    logic signed [33:0]  tprod_reg;
    logic [15:0]         gain4_reg, gain5_reg;
    logic [33:0]         tround;
    logic [15:0]         ts_reg;
    logic                f1_vld_reg, f2_vld_reg, f3_vld_reg, f4_vld_reg, f5_vld_reg;

    always_comb begin
        radius  = root_reg[K][POS_BITS-1:0];
        div_num = {dist_reg, 13'd0} + crfs_pkg::DIV_BIAS;
        tround  = 34'(tprod_reg) + 34'(32768);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
            f5_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= vld_reg[K];
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
            f5_vld_reg <= f4_vld_reg;
        end
        if (en) begin
            near_reg  <= radius < POS_BITS'(crfs_pkg::FALL_RADIUS);
            dist_reg  <= 13'(POS_BITS'(crfs_pkg::FALL_RADIUS) - radius);
            near2_reg <= near_reg;
            fprod_reg <= 52'(div_num) * 52'(crfs_pkg::RECIP_625);
            fall_reg  <= near2_reg ? fprod_reg[51:35] : 17'd0;
            tprod_reg <= 34'(cfg.tension_level) * $signed({17'd0, fall_reg});
            gain4_reg <= fall_reg[16] ? 16'hFFFF : fall_reg[15:0];
            // Arithmetic shift by 16 after the half-unit bias keeps the low 16 bits.
            ts_reg    <= tround[31:16];
            gain5_reg <= gain4_reg;
        end
    end

    assign out_valid      = f5_vld_reg;
    assign falloff_gain   = gain5_reg;
    assign scaled_tension = ts_reg;

endmodule

@@ src/chladni_ripple_field_sampler_core.sv @@
// Top level of the Chladni ripple field sampler: input register, settings registers,
// ripple and radial pipelines, and the output register with its skid stage.
// Depends on crfs_pkg, crfs_plate and crfs_radial.
`timescale 1ns / 1ps

// The core takes one world position per cycle while it is not stalled and returns one
// word per position, in order. The pipeline depth is set by the square root of
// x*x + y*y, which settles one root bit per pipeline stage; the ripple amplitude is
// computed alongside and delayed to match. Settings are to be written through the
// cfg port only while the core is idle; the user is bound by this, and the core itself
// does not enforce it. Pipeline stages read the settings live, so a write also reaches
// positions in flight. Output backpressure stalls the pipeline as a whole; the skid
// register keeps s_tready a registered signal. No clearing pass is needed after reset.
module chladni_ripple_field_sampler_core #(
    parameter int  COS_TABLE_BITS = 8,
    parameter int  POS_BITS       = 24,
    localparam int S_TDATA_W      = ((2 * POS_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input words.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pos_x, pos_y
    // Result words.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // ripple_amp, falloff_gain, scaled_tension
    // Settings writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int DLY = crfs_pkg::radial_lat(POS_BITS) - crfs_pkg::RIPPLE_LAT;

    // Settings registers.
    crfs_pkg::crfs_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (crfs_pkg::cfg_reg_t'(cfg_index))
                crfs_pkg::REG_MODE_N:  cfg_reg.mode_n        <= cfg_data[5:0];
                crfs_pkg::REG_MODE_M:  cfg_reg.mode_m        <= cfg_data[5:0];
                crfs_pkg::REG_TENSION: cfg_reg.tension_level <= $signed(cfg_data);
                crfs_pkg::REG_BEAT:    cfg_reg.beat_level    <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves whenever the skid register is free.
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Input register.
    logic                       in_vld_reg;
    logic signed [POS_BITS-1:0] x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
        if (en) begin
            x_reg <= $signed(s_tdata[POS_BITS-1:0]);
            y_reg <= $signed(s_tdata[2*POS_BITS-1:POS_BITS]);
        end
    end

    // Datapaths.
    logic [15:0] ripple_amp;
    logic        rad_valid;
    logic [15:0] falloff_gain;
    logic [15:0] scaled_tension;

    crfs_plate #(
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .POS_BITS       (POS_BITS)
    ) u_plate (
        .aclk       (aclk),
        .en         (en),
        .cfg        (cfg_reg),
        .pos_x      (x_reg),
        .pos_y      (y_reg),
        .ripple_amp (ripple_amp)
    );

    crfs_radial #(
        .POS_BITS (POS_BITS)
    ) u_radial (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .cfg            (cfg_reg),
        .in_valid       (in_vld_reg),
        .pos_x          (x_reg),
        .pos_y          (y_reg),
        .out_valid      (rad_valid),
        .falloff_gain   (falloff_gain),
        .scaled_tension (scaled_tension)
    );

    // Delay the ripple amplitude to line up with the longer radial path.
    logic [15:0] rdly_reg [DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            rdly_reg[0] <= ripple_amp;
            for (int i = 1; i < DLY; i++) begin
                rdly_reg[i] <= rdly_reg[i-1];
            end
        end
    end

    logic [47:0] pipe_data;

    assign pipe_data = {scaled_tension, falloff_gain, rdly_reg[DLY-1]};

    // Output register with a skid stage behind it.
    logic        main_valid_reg;
    logic [47:0] main_data_reg;
    logic [47:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!(main_valid_reg && !m_tready)) begin
            main_valid_reg <= rad_valid;
        end else if (rad_valid) begin
            skid_valid_reg <= 1'b1;
        end
        if (skid_valid_reg) begin
            if (m_tready) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (!(main_valid_reg && !m_tready)) begin
            main_data_reg <= pipe_data;
        end else begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule

@@ src/crfs_checker.sv @@
// Port-level checks for the Chladni ripple field sampler core.
// Bound to chladni_ripple_field_sampler_core; sees its ports only.
`timescale 1ns / 1ps

module crfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A held word keeps its value until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // Reset leaves no word on the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // Input is only held off while a word waits on the output.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output");

    // Zero falloff must give zero scaled tension.
    a_zero_falloff: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[31:16] == 16'd0)) |-> (m_tdata[47:32] == 16'd0))
        else $error("scaled tension nonzero outside falloff radius");

endmodule

bind chladni_ripple_field_sampler_core crfs_checker u_crfs_checker (.*);
